@@ design/fps_pkg.sv @@
package fps_pkg;

    // Buffer geometry
    localparam int BUFFER_WORDS = 64;
    localparam int BANK_DEPTH   = BUFFER_WORDS / 2;
    localparam int BANK_AW      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [8:0] BUF_WORDS_W = 9'(BUFFER_WORDS);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int OP_W    = 3;
    localparam int WIDX_W  = 6;
    localparam int WORD_W  = 32;
    localparam int FSTAT_W = 8;
    localparam int ADDR_W  = 24;
    localparam int LEN_W   = 7;
    localparam int POS_W   = 7;
    localparam int FCMD_W  = 4;
    localparam int SCODE_W = 2;
    localparam int CFG_IDX_W = 8;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

    // Start operations
    localparam logic [OP_W-1:0] OP_ERASE = 3'd0;
    localparam logic [OP_W-1:0] OP_PROG  = 3'd1;

    // Flash command codes
    localparam logic [FCMD_W-1:0] FC_ERASE = 4'h8;
    localparam logic [FCMD_W-1:0] FC_PROG  = 4'h6;

    // Report codes
    localparam logic [SCODE_W-1:0] ST_OK      = 2'd0;
    localparam logic [SCODE_W-1:0] ST_FERR    = 2'd1;
    localparam logic [SCODE_W-1:0] ST_NOTIMPL = 2'd2;

    // Result kinds
    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN  = 8'd1;

    typedef enum logic [1:0] {
        PH_READY,
        PH_PROG_WAIT,
        PH_FINAL_WAIT
    } t_phase;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_CMD_WRITE,
        C_CMD_STATUS,
        C_CMD_NOT_START,
        C_BUSY,
        C_OP_ERASE,
        C_OP_NOT_PROG,
        C_IGNORE_STAT,
        C_STAT_ERR,
        C_FINAL,
        C_POS_DONE,
        C_OUT_FULL
    } t_cond;

    // Result loads
    typedef enum logic [2:0] {
        EM_NONE,
        EM_ERASE,
        EM_PROG,
        EM_OK,
        EM_FERR,
        EM_NOTIMPL
    } t_emit;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    // Program step labels
    localparam t_upc U_IDLE     = 5'd0;
    localparam t_upc U_DISP_WR  = 5'd1;
    localparam t_upc U_DISP_ST  = 5'd2;
    localparam t_upc U_DISP_CMD = 5'd3;
    localparam t_upc U_CHK_BUSY = 5'd4;
    localparam t_upc U_DISP_ER  = 5'd5;
    localparam t_upc U_DISP_PR  = 5'd6;
    localparam t_upc U_PROG_GO  = 5'd7;
    localparam t_upc U_STATUS   = 5'd8;
    localparam t_upc U_STAT_ERR = 5'd9;
    localparam t_upc U_STAT_FIN = 5'd10;
    localparam t_upc U_STAT_NXT = 5'd11;
    localparam t_upc U_WRITE    = 5'd12;
    localparam t_upc U_ER_WAIT  = 5'd13;
    localparam t_upc U_ER_EMIT  = 5'd14;
    localparam t_upc U_NI_WAIT  = 5'd15;
    localparam t_upc U_NI_EMIT  = 5'd16;
    localparam t_upc U_LOAD     = 5'd17;
    localparam t_upc U_PR_WAIT  = 5'd18;
    localparam t_upc U_PR_EMIT  = 5'd19;
    localparam t_upc U_PR_END   = 5'd20;
    localparam t_upc U_FE_WAIT  = 5'd21;
    localparam t_upc U_FE_EMIT  = 5'd22;
    localparam t_upc U_OK_WAIT  = 5'd23;
    localparam t_upc U_OK_EMIT  = 5'd24;

    typedef struct packed {
        t_cond  cond;
        t_upc   target;
        logic   ready;
        logic   buf_wr;
        logic   pos_clr;
        logic   pos_inc;
        logic   phase_we;
        t_phase phase_val;
        t_emit  emit;
    } t_uword;

endpackage

@@ design/fps_ucode_rom.sv @@
module fps_ucode_rom (
    input  fps_pkg::t_upc   i_upc,
    output fps_pkg::t_uword o_uword
);
    import fps_pkg::*;

    always_comb begin
        o_uword           = '0;
        o_uword.cond      = C_ALWAYS;
        o_uword.target    = U_IDLE;
        o_uword.phase_val = PH_READY;
        o_uword.emit      = EM_NONE;
        case (i_upc)
            U_IDLE: begin
                o_uword.ready = 1'b1;
                o_uword.cond  = C_NO_ACCEPT;
            end
            U_DISP_WR: begin
                o_uword.cond   = C_CMD_WRITE;
                o_uword.target = U_WRITE;
            end
            U_DISP_ST: begin
                o_uword.cond   = C_CMD_STATUS;
                o_uword.target = U_STATUS;
            end
            U_DISP_CMD: o_uword.cond = C_CMD_NOT_START;
            U_CHK_BUSY: o_uword.cond = C_BUSY;
            U_DISP_ER: begin
                o_uword.cond   = C_OP_ERASE;
                o_uword.target = U_ER_WAIT;
            end
            U_DISP_PR: begin
                o_uword.cond   = C_OP_NOT_PROG;
                o_uword.target = U_NI_WAIT;
            end
            U_PROG_GO: begin
                o_uword.pos_clr = 1'b1;
                o_uword.target  = U_LOAD;
            end
            U_STATUS: o_uword.cond = C_IGNORE_STAT;
            U_STAT_ERR: begin
                o_uword.cond   = C_STAT_ERR;
                o_uword.target = U_FE_WAIT;
            end
            U_STAT_FIN: begin
                o_uword.cond   = C_FINAL;
                o_uword.target = U_OK_WAIT;
            end
            U_STAT_NXT: begin
                o_uword.pos_inc = 1'b1;
                o_uword.target  = U_LOAD;
            end
            U_WRITE: o_uword.buf_wr = 1'b1;
            U_ER_WAIT: begin
                o_uword.cond   = C_OUT_FULL;
                o_uword.target = U_ER_WAIT;
            end
            U_ER_EMIT: begin
                o_uword.emit      = EM_ERASE;
                o_uword.phase_we  = 1'b1;
                o_uword.phase_val = PH_FINAL_WAIT;
            end
            U_NI_WAIT: begin
                o_uword.cond   = C_OUT_FULL;
                o_uword.target = U_NI_WAIT;
            end
            U_NI_EMIT: o_uword.emit = EM_NOTIMPL;
            U_LOAD: begin
                o_uword.cond   = C_POS_DONE;
                o_uword.target = U_PR_END;
            end
            U_PR_WAIT: begin
                o_uword.cond   = C_OUT_FULL;
                o_uword.target = U_PR_WAIT;
            end
            U_PR_EMIT: begin
                o_uword.emit      = EM_PROG;
                o_uword.phase_we  = 1'b1;
                o_uword.phase_val = PH_PROG_WAIT;
            end
            U_PR_END: begin
                o_uword.phase_we  = 1'b1;
                o_uword.phase_val = PH_FINAL_WAIT;
            end
            U_FE_WAIT: begin
                o_uword.cond   = C_OUT_FULL;
                o_uword.target = U_FE_WAIT;
            end
            U_FE_EMIT: begin
                o_uword.emit     = EM_FERR;
                o_uword.phase_we = 1'b1;
            end
            U_OK_WAIT: begin
                o_uword.cond   = C_OUT_FULL;
                o_uword.target = U_OK_WAIT;
            end
            U_OK_EMIT: begin
                o_uword.emit     = EM_OK;
                o_uword.phase_we = 1'b1;
            end
            default: o_uword.cond = C_ALWAYS;
        endcase
    end

endmodule

@@ design/fps_buffer.sv @@
module fps_buffer (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [fps_pkg::WIDX_W-1:0]  i_widx,
    input  logic [fps_pkg::WORD_W-1:0]  i_wdata,
    input  logic [fps_pkg::POS_W-1:0]   i_rpos,
    output logic [fps_pkg::WORD_W-1:0]  o_lo,
    output logic [fps_pkg::WORD_W-1:0]  o_hi
);
    import fps_pkg::*;

    // Even words in one bank, odd words in the other: one phrase per row
    logic [WORD_W-1:0] r_mem_even [BANK_DEPTH];
    logic [WORD_W-1:0] r_mem_odd  [BANK_DEPTH];

    logic [8:0]         widx_x;
    logic [8:0]         rpos_x;
    logic [BANK_AW-1:0] wrow;
    logic [BANK_AW-1:0] rrow;
    logic               in_range;

    assign widx_x   = {3'b000, i_widx};
    assign rpos_x   = {2'b00, i_rpos};
    assign wrow     = widx_x[BANK_AW:1];
    assign rrow     = rpos_x[BANK_AW:1];
    assign in_range = (widx_x < BUF_WORDS_W);

    always_ff @(posedge i_clk) begin
        if (i_we && in_range && !widx_x[0]) begin
            r_mem_even[wrow] <= i_wdata;
        end
        if (i_we && in_range && widx_x[0]) begin
            r_mem_odd[wrow] <= i_wdata;
        end
        o_lo <= r_mem_even[rrow];
        o_hi <= r_mem_odd[rrow];
    end

endmodule

@@ design/flash_program_sequencer.sv @@
// Flash program sequencer. A host streams transactions into the slave side:
// tuser selects a start, a buffer word write or a flash status sample. Buffer
// writes fill a 64-word buffer; a start with op 0 issues one mass erase
// command, op 1 issues one program-phrase command per pair of buffer words at
// base_address + index*4, waiting for a clean completion (status bit 7 with
// no other bit set) after each phrase and once more before reporting OK.
// Any completion carrying error bits aborts with a flash-error report holding
// the status byte; other ops report not-implemented. Results leave through a
// registered master side: tuser 0 is a flash command, 1 a host report. Control
// is a microprogram of steps; a transaction that emits a result waits while the
// previous result is still held in the output register. Configuration writes
// are always accepted and take effect at once; write them only while idle.
module flash_program_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave side
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [2:0] op, [8:3] word_index, [40:9] word_data, [48:41] fstat, [55:49] zero
    input  logic [55:0]   i_s_tdata,
    // [1:0] cmd
    input  logic [1:0]    i_s_tuser,
    // master side
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [3:0] flash_cmd, [27:4] flash_addr, [59:28] phrase_low,
    // [91:60] phrase_high, [93:92] status_code, [101:94] error_bits,
    // [103:102] zero
    output logic [103:0]  o_m_tdata,
    // [0] kind
    output logic          o_m_tuser,
    // configuration write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [23:0]   i_cfg_data
);
    import fps_pkg::*;

    // Microsequencer
    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   cond_true;
    logic   in_acc;

    // Latched transaction
    logic [CMD_W-1:0]   r_cmd;
    logic [OP_W-1:0]    r_op;
    logic [WIDX_W-1:0]  r_widx;
    logic [WORD_W-1:0]  r_wdata;
    logic [FSTAT_W-1:0] r_fstat;

    // Configuration
    logic [ADDR_W-1:0] r_base_addr;
    logic [LEN_W-1:0]  r_word_len;

    // Sequencing state
    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_word_pos, n_word_pos;

    // Buffer read data for the phrase at r_word_pos
    logic [WORD_W-1:0] buf_lo, buf_hi;

    // Output register
    logic              r_out_valid;
    logic              r_kind;
    logic [FCMD_W-1:0] r_fcmd;
    logic [ADDR_W-1:0] r_faddr;
    logic [WORD_W-1:0] r_plo, r_phi;
    logic [SCODE_W-1:0] r_scode;
    logic [FSTAT_W-1:0] r_ebits;

    // Output register load values
    logic               n_kind;
    logic [FCMD_W-1:0]  n_fcmd;
    logic [ADDR_W-1:0]  n_faddr;
    logic [WORD_W-1:0]  n_plo, n_phi;
    logic [SCODE_W-1:0] n_scode;
    logic [FSTAT_W-1:0] n_ebits;

    logic [8:0]        eff_len;
    logic [8:0]        len_x;
    logic [ADDR_W-1:0] phrase_addr;

    fps_ucode_rom u_rom (
        .i_upc   (r_upc),
        .o_uword (uw)
    );

    fps_buffer u_buf (
        .i_clk   (i_clk),
        .i_we    (uw.buf_wr),
        .i_widx  (r_widx),
        .i_wdata (r_wdata),
        .i_rpos  (r_word_pos),
        .o_lo    (buf_lo),
        .o_hi    (buf_hi)
    );

    assign o_s_tready  = uw.ready;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Clamp the programmed length to the buffer size; read live
    assign len_x       = {2'b00, r_word_len};
    assign eff_len     = (len_x > BUF_WORDS_W) ? BUF_WORDS_W : len_x;
    assign phrase_addr = r_base_addr + {15'd0, r_word_pos, 2'b00};

    // Jump condition
    always_comb begin
        case (uw.cond)
            C_NEVER:         cond_true = 1'b0;
            C_ALWAYS:        cond_true = 1'b1;
            C_NO_ACCEPT:     cond_true = !in_acc;
            C_CMD_WRITE:     cond_true = (r_cmd == CMD_WRITE);
            C_CMD_STATUS:    cond_true = (r_cmd == CMD_STATUS);
            C_CMD_NOT_START: cond_true = (r_cmd != CMD_START);
            C_BUSY:          cond_true = (r_phase != PH_READY);
            C_OP_ERASE:      cond_true = (r_op == OP_ERASE);
            C_OP_NOT_PROG:   cond_true = (r_op != OP_PROG);
            C_IGNORE_STAT:   cond_true = (r_phase == PH_READY) || !r_fstat[7];
            C_STAT_ERR:      cond_true = (r_fstat[6:0] != 7'd0);
            C_FINAL:         cond_true = (r_phase == PH_FINAL_WAIT);
            C_POS_DONE:      cond_true = ({2'b00, r_word_pos} >= eff_len);
            C_OUT_FULL:      cond_true = r_out_valid && !i_m_tready;
            default:         cond_true = 1'b1;
        endcase
    end

    // Next step and state updates
    always_comb begin
        n_upc      = cond_true ? uw.target : r_upc + t_upc'(1);
        n_phase    = uw.phase_we ? uw.phase_val : r_phase;
        n_word_pos = r_word_pos;
        if (uw.pos_clr) begin
            n_word_pos = '0;
        end else if (uw.pos_inc) begin
            n_word_pos = r_word_pos + POS_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc      <= U_IDLE;
            r_phase    <= PH_READY;
            r_word_pos <= '0;
        end else begin
            r_upc      <= n_upc;
            r_phase    <= n_phase;
            r_word_pos <= n_word_pos;
        end
    end

    // Capture the transaction on acceptance
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_s_tuser;
            r_op    <= i_s_tdata[2:0];
            r_widx  <= i_s_tdata[8:3];
            r_wdata <= i_s_tdata[40:9];
            r_fstat <= i_s_tdata[48:41];
        end
    end

    // Configuration registers; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr <= '0;
            r_word_len  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_BASE_ADDR) begin
                r_base_addr <= i_cfg_data;
            end else if (i_cfg_index == CFG_WORD_LEN) begin
                r_word_len <= i_cfg_data[LEN_W-1:0];
            end
        end
    end

    // Output register: load on an emit step, release when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.emit != EM_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Build the result for the current emit step
    always_comb begin
        n_kind  = KIND_REPORT;
        n_fcmd  = '0;
        n_faddr = '0;
        n_plo   = '0;
        n_phi   = '0;
        n_scode = ST_OK;
        n_ebits = '0;
        case (uw.emit)
            EM_ERASE: begin
                n_kind = KIND_CMD;
                n_fcmd = FC_ERASE;
            end
            EM_PROG: begin
                n_kind  = KIND_CMD;
                n_fcmd  = FC_PROG;
                n_faddr = phrase_addr;
                n_plo   = buf_lo;
                n_phi   = buf_hi;
            end
            EM_FERR: begin
                n_scode = ST_FERR;
                n_ebits = r_fstat;
            end
            EM_NOTIMPL: n_scode = ST_NOTIMPL;
            default:    n_scode = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (uw.emit != EM_NONE) begin
            r_kind  <= n_kind;
            r_fcmd  <= n_fcmd;
            r_faddr <= n_faddr;
            r_plo   <= n_plo;
            r_phi   <= n_phi;
            r_scode <= n_scode;
            r_ebits <= n_ebits;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tdata  = {2'b00, r_ebits, r_scode, r_phi, r_plo, r_faddr, r_fcmd};

endmodule

@@ tb/sv/flash_program_sequencer_tb.sv @@
module flash_program_sequencer_tb;
    import fps_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [CMD_W-1:0]     CMD_UNUSED     = 2'd3;
    localparam logic [OP_W-1:0]      OP_FIRST_UNSUP = 3'd2;
    localparam logic [OP_W-1:0]      OP_LAST_UNSUP  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 8'hFF;
    localparam logic [FSTAT_W-1:0]   FS_DONE        = 8'h80;
    localparam logic [FSTAT_W-1:0]   FS_NONE        = 8'h00;

    // Quiet cycles allowed at a phase boundary, and the watchdog limit
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // One host transaction on the slave side
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [OP_W-1:0]    op;
        logic [WIDX_W-1:0]  word_index;
        logic [WORD_W-1:0]  word_data;
        logic [FSTAT_W-1:0] fstat;
    } t_host_txn;

    // One flash command or host report on the master side
    typedef struct packed {
        logic               kind;
        logic [FCMD_W-1:0]  flash_cmd;
        logic [ADDR_W-1:0]  flash_addr;
        logic [WORD_W-1:0]  phrase_low;
        logic [WORD_W-1:0]  phrase_high;
        logic [SCODE_W-1:0] status_code;
        logic [FSTAT_W-1:0] error_bits;
    } t_flash_out;

    // DUT pins; every input starts at a known value
    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [55:0]  i_s_tdata   = '0;
    logic [1:0]   i_s_tuser   = '0;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [103:0] o_m_tdata;
    logic         o_m_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [23:0]  i_cfg_data  = '0;

    flash_program_sequencer DUT (.*);

    always #5 i_clk = ~i_clk;

    // Host transactions waiting for the driver, and commands/reports still due
    t_host_txn  host_txn_q[$];
    t_flash_out cmd_report_q[$];

    // Handshakes seen at the last rising edge
    bit in_fire, out_fire, cfg_fire;

    int n_pushed    = 0;
    int n_accepted  = 0;
    int fail_count  = 0;
    int quiet_cycles = 0;

    // Idle and stall pressure, as a percentage per cycle
    int idle_pct  = 0;
    int stall_pct = 0;
    int gap_left   = 0;
    int stall_left = 0;

    // Generator view: words written so far and the length currently set
    bit [BUFFER_WORDS-1:0] words_loaded = '0;
    logic [LEN_W-1:0]      gen_len      = '0;

    // ------------------------------------------------------------------
    // Sequencer prediction: own copy of registers, phase, index and buffer
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] sq_base  = '0;
    logic [LEN_W-1:0]  sq_len   = '0;
    t_phase            sq_phase = PH_READY;
    logic [8:0]        sq_pos   = '0;
    logic [WORD_W-1:0] sq_image [BUFFER_WORDS];

    // Length in use: the register clamped to the buffer size
    function automatic int clamp_len(input logic [LEN_W-1:0] len);
        return (int'(len) > BUFFER_WORDS) ? BUFFER_WORDS : int'(len);
    endfunction

    function automatic logic [WORD_W-1:0] image_word(input int idx);
        return (idx < BUFFER_WORDS) ? sq_image[idx] : '0;
    endfunction

    function automatic t_flash_out host_report(input logic [SCODE_W-1:0] code,
                                               input logic [FSTAT_W-1:0] bits);
        t_flash_out r;
        r = '0;
        r.kind        = KIND_REPORT;
        r.status_code = code;
        r.error_bits  = bits;
        return r;
    endfunction

    // Issue the phrase at the current index, or fall into the final wait
    function automatic bit next_phrase(output t_flash_out r);
        int idx;
        r   = '0;
        idx = int'(sq_pos[7:0] & 8'hFE);
        if (int'(sq_pos) >= clamp_len(sq_len)) begin
            sq_phase = PH_FINAL_WAIT;
            return 1'b0;
        end
        r.kind        = KIND_CMD;
        r.flash_cmd   = FC_PROG;
        r.flash_addr  = sq_base + ADDR_W'(idx) * 24'd4;
        r.phrase_low  = image_word(idx);
        r.phrase_high = image_word(idx + 1);
        sq_phase = PH_PROG_WAIT;
        return 1'b1;
    endfunction

    // Advance the sequencer by one host transaction
    function automatic bit sequencer_step(input t_host_txn t, output t_flash_out r);
        bit hit;
        hit = 1'b0;
        r   = '0;
        if (t.cmd == CMD_WRITE) begin
            if (int'(t.word_index) < BUFFER_WORDS)
                sq_image[t.word_index] = t.word_data;
        end else if (t.cmd == CMD_START) begin
            if (sq_phase == PH_READY) begin
                hit = 1'b1;
                if (t.op == OP_ERASE) begin
                    r.kind      = KIND_CMD;
                    r.flash_cmd = FC_ERASE;
                    sq_phase    = PH_FINAL_WAIT;
                end else if (t.op == OP_PROG) begin
                    sq_pos = '0;
                    hit    = next_phrase(r);
                end else begin
                    r = host_report(ST_NOTIMPL, '0);
                end
            end
        end else if (t.cmd == CMD_STATUS) begin
            if (sq_phase != PH_READY && t.fstat[7]) begin
                hit = 1'b1;
                if (t.fstat[6:0] != '0) begin
                    sq_phase = PH_READY;
                    r = host_report(ST_FERR, t.fstat);
                end else if (sq_phase == PH_PROG_WAIT) begin
                    sq_pos = sq_pos + 9'd2;
                    hit    = next_phrase(r);
                end else begin
                    sq_phase = PH_READY;
                    r = host_report(ST_OK, '0);
                end
            end
        end
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample handshakes, feed the prediction, compare results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor_p
        t_host_txn  txn;
        t_flash_out due, seen;
        in_fire  = i_s_tvalid && o_s_tready;
        out_fire = o_m_tvalid && i_m_tready;
        cfg_fire = i_cfg_valid && o_cfg_ready;

        // Apply register writes in the order the block sees them
        if (cfg_fire) begin
            if (i_cfg_index == CFG_BASE_ADDR)
                sq_base = i_cfg_data;
            else if (i_cfg_index == CFG_WORD_LEN)
                sq_len = i_cfg_data[LEN_W-1:0];
        end

        if (in_fire) begin
            n_accepted++;
            txn.cmd        = i_s_tuser;
            txn.op         = i_s_tdata[2:0];
            txn.word_index = i_s_tdata[8:3];
            txn.word_data  = i_s_tdata[40:9];
            txn.fstat      = i_s_tdata[48:41];
            if (sequencer_step(txn, due))
                cmd_report_q.push_back(due);
        end

        if (out_fire) begin
            seen.kind        = o_m_tuser;
            seen.flash_cmd   = o_m_tdata[3:0];
            seen.flash_addr  = o_m_tdata[27:4];
            seen.phrase_low  = o_m_tdata[59:28];
            seen.phrase_high = o_m_tdata[91:60];
            seen.status_code = o_m_tdata[93:92];
            seen.error_bits  = o_m_tdata[101:94];
            if (cmd_report_q.size() == 0) begin
                $display("%0t: result mismatch, expected none, actual kind %h data %h",
                         $time, o_m_tuser, o_m_tdata);
                fail_count++;
            end else begin
                due = cmd_report_q.pop_front();
                check_field("kind",        32'(due.kind),        32'(seen.kind));
                check_field("flash_cmd",   32'(due.flash_cmd),   32'(seen.flash_cmd));
                check_field("flash_addr",  32'(due.flash_addr),  32'(seen.flash_addr));
                check_field("phrase_low",  due.phrase_low,       seen.phrase_low);
                check_field("phrase_high", due.phrase_high,      seen.phrase_high);
                check_field("status_code", 32'(due.status_code), 32'(seen.status_code));
                check_field("error_bits",  32'(due.error_bits),  32'(seen.error_bits));
            end
        end

        // Watchdog: count cycles with no transaction on any channel
        if (in_fire || out_fire || cfg_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: present queued host transactions, with random idle bursts
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : host_drive_p
        t_host_txn nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !in_fire) begin
            // hold the transaction until it is taken
        end else if (gap_left != 0) begin
            gap_left--;
            i_s_tvalid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap_left = $urandom_range(12, 1) - 1;
            i_s_tvalid <= 1'b0;
        end else if (host_txn_q.size() != 0) begin
            nxt = host_txn_q.pop_front();
            i_s_tdata  <= {7'b0, nxt.fstat, nxt.word_data, nxt.word_index, nxt.op};
            i_s_tuser  <= nxt.cmd;
            i_s_tvalid <= 1'b1;
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Receiver: stall the master side in random bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(12, 1) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [OP_W-1:0] op,
                             input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wdata,
                             input logic [FSTAT_W-1:0] fstat);
        t_host_txn t;
        t.cmd        = cmd;
        t.op         = op;
        t.word_index = widx;
        t.word_data  = wdata;
        t.fstat      = fstat;
        if (cmd == CMD_WRITE)
            words_loaded[widx] = 1'b1;
        host_txn_q.push_back(t);
        n_pushed++;
    endtask

    // Write every word a phrase can read at the current length, so that no
    // program command ever picks up a buffer entry that was never written
    task automatic load_needed_words();
        int n;
        n = clamp_len(gen_len);
        n = (n + 1) & ~1;
        if (n > BUFFER_WORDS)
            n = BUFFER_WORDS;
        for (int i = 0; i < n; i++)
            if (!words_loaded[i])
                push_item(CMD_WRITE, 3'($urandom), WIDX_W'(i), $urandom, 8'($urandom));
    endtask

    // Filler between completions: status without the done bit, a buffer
    // write, or a start that should land while the block is busy
    task automatic push_noise();
        case ($urandom_range(2))
            0: push_item(CMD_STATUS, 3'($urandom), 6'($urandom), $urandom,
                         {1'b0, 7'($urandom)});
            1: push_item(CMD_WRITE, 3'($urandom), 6'($urandom), $urandom, 8'($urandom));
            default: push_item(CMD_START, 3'($urandom), 6'($urandom), $urandom,
                               8'($urandom));
        endcase
    endtask

    // Completion: clean most of the time, otherwise with error bits
    task automatic push_completion(output bit failed);
        failed = ($urandom_range(19) == 0);
        push_item(CMD_STATUS, 3'($urandom), 6'($urandom), $urandom,
                  failed ? {1'b1, 7'($urandom_range(127, 1))} : FS_DONE);
    endtask

    // One random sequence: mostly well-formed program or erase runs
    task automatic push_sequence();
        int sel, steps;
        bit failed;
        sel = $urandom_range(99);
        if (sel < 45) begin
            repeat ($urandom_range(2))
                push_item(CMD_WRITE, 3'($urandom), 6'($urandom), $urandom, 8'($urandom));
            push_item(CMD_START, OP_PROG, 6'($urandom), $urandom, 8'($urandom));
            steps = (clamp_len(gen_len) + 1) / 2 + 1;
            for (int k = 0; k < steps; k++) begin
                if ($urandom_range(3) == 0)
                    push_noise();
                push_completion(failed);
                if (failed)
                    break;
            end
        end else if (sel < 65) begin
            push_item(CMD_START, OP_ERASE, 6'($urandom), $urandom, 8'($urandom));
            repeat ($urandom_range(2))
                push_noise();
            push_completion(failed);
        end else if (sel < 75) begin
            push_item(CMD_START, 3'($urandom_range(OP_LAST_UNSUP, OP_FIRST_UNSUP)),
                      6'($urandom), $urandom, 8'($urandom));
        end else begin
            push_item(2'($urandom_range(3)), 3'($urandom), 6'($urandom), $urandom,
                      8'($urandom));
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold off until every queued transaction is taken and every result is
    // in, then let the block finish any transaction that emits nothing
    task automatic drain_block();
        while (n_accepted != n_pushed)
            @(negedge i_clk);
        while (cmd_report_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [23:0] base, input logic [LEN_W-1:0] len,
                             input int n, input int idle, input int stall);
        int goal;
        cfg_write(CFG_BASE_ADDR, base);
        cfg_write(CFG_WORD_LEN, 24'(len));
        gen_len   = len;
        idle_pct  = idle;
        stall_pct = stall;
        load_needed_words();
        goal = n_pushed + n;
        while (n_pushed < goal)
            push_sequence();
        drain_block();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < BUFFER_WORDS; i++)
            sq_image[i] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: base near the top so that the last phrase wraps
        cfg_write(CFG_BASE_ADDR, 24'hFFFFF0);
        cfg_write(CFG_WORD_LEN, 24'd5);
        gen_len   = 7'd5;
        idle_pct  = 20;
        stall_pct = 20;
        push_item(CMD_WRITE, 3'd0, 6'd0, 32'h0000_0000, FS_NONE);
        push_item(CMD_WRITE, 3'd7, 6'd1, 32'hFFFF_FFFF, 8'hFF);
        load_needed_words();
        // completion while ready and the unused command: both dropped
        push_item(CMD_STATUS, OP_ERASE, 6'd0, 32'h0, FS_DONE);
        push_item(CMD_UNUSED, OP_PROG, 6'd63, 32'h1234_5678, FS_DONE);
        // unsupported ops report and stay ready
        push_item(CMD_START, OP_FIRST_UNSUP, 6'd0, 32'h0, FS_NONE);
        push_item(CMD_START, OP_LAST_UNSUP, 6'd0, 32'h0, FS_NONE);
        // erase; a start while busy is dropped, a write while busy is taken,
        // a status without the done bit is dropped
        push_item(CMD_START, OP_ERASE, 6'd0, 32'h0, FS_NONE);
        push_item(CMD_START, OP_PROG, 6'd0, 32'h0, FS_NONE);
        push_item(CMD_STATUS, OP_ERASE, 6'd0, 32'h0, FS_NONE);
        push_item(CMD_WRITE, OP_ERASE, 6'd3, 32'hA5A5_A5A5, FS_NONE);
        push_item(CMD_STATUS, OP_ERASE, 6'd0, 32'h0, FS_DONE);
        // program five words: three phrases, the final wait, then OK
        push_item(CMD_START, OP_PROG, 6'd0, 32'h0, FS_NONE);
        repeat (4) push_item(CMD_STATUS, OP_ERASE, 6'd0, 32'h0, FS_DONE);
        // completions carrying error bits abort both operations
        push_item(CMD_START, OP_ERASE, 6'd0, 32'h0, FS_NONE);
        push_item(CMD_STATUS, OP_ERASE, 6'd0, 32'h0, 8'hFF);
        push_item(CMD_START, OP_PROG, 6'd0, 32'h0, FS_NONE);
        push_item(CMD_STATUS, OP_ERASE, 6'd0, 32'h0, 8'h81);
        drain_block();

        // Random part, register settings from zero length to beyond the buffer
        run_phase(24'h000000, 7'd0, 40, 20, 20);
        run_phase(24'($urandom), 7'd2, 150, 10, 25);
        run_phase(24'hFFFFFF, 7'd64, 120, 15, 10);
        cfg_write(CFG_UNUSED, 24'($urandom));
        run_phase(24'($urandom), 7'd127, 100, 5, 5);
        run_phase(24'($urandom), 7'($urandom_range(9, 1)), 150, 25, 25);
        run_phase(24'($urandom), 7'($urandom_range(8, 3)), 120, 10, 10);
        // last stretch with neither side idling
        run_phase(24'($urandom), 7'd1, 120, 0, 0);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/fps_pkg.sv
design/fps_ucode_rom.sv
design/fps_buffer.sv
design/flash_program_sequencer.sv
tb/sv/flash_program_sequencer_tb.sv
